// ----- design/rfr_pkg.sv -----
// shared types, constants and crc helper for the response frame receiver
package rfr_pkg;

  localparam int BUFFER_BYTES = 128;
  localparam int CNT_W        = 10;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0]      CRC_POLY     = 16'hA001;
  localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] QUIET_RST    = CNT_W'(40);
  localparam logic [CNT_W-1:0] TIMEOUT_RST  = CNT_W'(600);
  localparam logic [7:0]       HDR_B0       = 8'd2;
  localparam logic [7:0]       HDR_B1       = 8'd65;
  localparam logic [7:0]       HDR_B2       = 8'd6;
  localparam logic [7:0]       OVH_CRC      = 8'd10;
  localparam logic [7:0]       OVH_HDR      = 8'd8;
  localparam logic [7:0]       MIN_LEN_CRC  = 8'd5;
  localparam logic [7:0]       MIN_LEN_HDR  = 8'd3;

  // input func codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_VARIANT = 2'd0;
  localparam logic [1:0] CFG_QUIET   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [1:0] VARIANT_HDR = 2'd1;

  // outcome codes
  localparam logic [1:0] OUT_GOOD    = 2'd0;
  localparam logic [1:0] OUT_NO_RESP = 2'd1;
  localparam logic [1:0] OUT_INVALID = 2'd2;

  // end causes
  localparam logic [1:0] END_FULL    = 2'd0;
  localparam logic [1:0] END_QUIET   = 2'd1;
  localparam logic [1:0] END_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       index;
    logic [CNT_W-1:0] wdata;
  } cfg_wr_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/rfr_front.sv -----
// front stage: takes input words, decodes func and registers the operation
module rfr_front import rfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_rx_byte,
  output logic       push,
  output op_t        push_op,
  input  logic       q_ready
);

  logic     vld_r;
  logic     vld_nxt;
  op_t      op_r;
  op_t      op_nxt;
  logic     take;
  logic     keep;
  op_kind_t kind;

  assign push     = vld_r && q_ready;
  assign in_ready = !vld_r || q_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    kind = OP_START;
    keep = 1'b1;
    case (in_func)
      FUNC_START: kind = OP_START;
      FUNC_BYTE:  kind = OP_BYTE;
      FUNC_TICK:  kind = OP_TICK;
      default:    keep = 1'b0;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    op_nxt  = op_r;
    if (push) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt = keep;
      op_nxt  = '{kind: kind, data: in_rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    op_r <= op_nxt;
  end

  assign push_op = op_r;

endmodule

// ----- design/rfr_queue.sv -----
// short operation queue between front and back
module rfr_queue import rfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output op_t  pop_op
);

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign q_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign pop_op  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_ready || pop))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- design/rfr_back.sv -----
// back end: frame state, crc, end detection, validation and result register
module rfr_back import rfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg,
  input  logic       q_valid,
  input  op_t        pop_op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_outcome,
  output logic [1:0] out_end_cause,
  output logic [7:0] out_frame_len,
  output logic [6:0] out_data_len
);

  logic [1:0]       variant_r;
  logic [CNT_W-1:0] quiet_ticks_r;
  logic [CNT_W-1:0] timeout_ticks_r;

  logic             waiting_r, waiting_nxt;
  logic [7:0]       byte_cnt_r, byte_cnt_nxt;
  logic [CNT_W-1:0] quiet_cnt_r, quiet_cnt_nxt;
  logic [CNT_W-1:0] elapsed_cnt_r, elapsed_cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       recent_r [3];
  logic [7:0]       recent_nxt [3];
  logic             hdr_ok_r, hdr_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       outcome_r, outcome_nxt;
  logic [1:0]       cause_r, cause_nxt;
  logic [7:0]       frame_len_r, frame_len_nxt;
  logic [6:0]       data_len_r, data_len_nxt;

  logic             back_ready;
  logic             active;
  logic             finish;
  logic             valid_frame;
  logic [7:0]       overhead;
  logic [7:0]       diff;

  assign back_ready = !out_valid_r || out_ready;
  assign pop        = q_valid && back_ready;
  assign active     = pop && waiting_r && (pop_op.kind != OP_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r       <= '0;
      quiet_ticks_r   <= QUIET_RST;
      timeout_ticks_r <= TIMEOUT_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_VARIANT: variant_r       <= cfg.wdata[1:0];
        CFG_QUIET:   quiet_ticks_r   <= cfg.wdata;
        CFG_TIMEOUT: timeout_ticks_r <= cfg.wdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    waiting_nxt     = waiting_r;
    byte_cnt_nxt    = byte_cnt_r;
    quiet_cnt_nxt   = quiet_cnt_r;
    elapsed_cnt_nxt = elapsed_cnt_r;
    crc_nxt         = crc_r;
    recent_nxt      = recent_r;
    hdr_ok_nxt      = hdr_ok_r;
    finish          = 1'b0;
    cause_nxt       = END_FULL;

    if (pop && pop_op.kind == OP_START) begin
      waiting_nxt     = 1'b1;
      byte_cnt_nxt    = '0;
      quiet_cnt_nxt   = '0;
      elapsed_cnt_nxt = '0;
      crc_nxt         = CRC_INIT;
      recent_nxt      = '{default: 8'h00};
      hdr_ok_nxt      = 1'b0;
    end else if (active) begin
      case (pop_op.kind)
        OP_BYTE: begin
          if (byte_cnt_r < 8'(BUFFER_BYTES)) begin
            if (byte_cnt_r >= 8'd4) begin
              crc_nxt = crc_feed(crc_r, recent_r[2]);
            end
            case (byte_cnt_r)
              8'd0:    hdr_ok_nxt = pop_op.data == HDR_B0;
              8'd1:    hdr_ok_nxt = hdr_ok_r && (pop_op.data == HDR_B1);
              8'd2:    hdr_ok_nxt = hdr_ok_r && (pop_op.data == HDR_B2);
              default: hdr_ok_nxt = hdr_ok_r;
            endcase
            recent_nxt[2] = recent_r[1];
            recent_nxt[1] = recent_r[0];
            recent_nxt[0] = pop_op.data;
            byte_cnt_nxt  = byte_cnt_r + 8'd1;
            quiet_cnt_nxt = '0;
          end
        end
        OP_TICK: begin
          if (quiet_cnt_r != CNT_MAX) begin
            quiet_cnt_nxt = quiet_cnt_r + 1'b1;
          end
          if (elapsed_cnt_r != CNT_MAX) begin
            elapsed_cnt_nxt = elapsed_cnt_r + 1'b1;
          end
        end
        default: ;
      endcase

      if (byte_cnt_nxt >= 8'(BUFFER_BYTES)) begin
        finish    = 1'b1;
        cause_nxt = END_FULL;
      end else if (byte_cnt_nxt != '0 && quiet_cnt_nxt >= quiet_ticks_r) begin
        finish    = 1'b1;
        cause_nxt = END_QUIET;
      end else if (elapsed_cnt_nxt >= timeout_ticks_r) begin
        finish    = 1'b1;
        cause_nxt = END_TIMEOUT;
      end
      if (finish) begin
        waiting_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (variant_r == VARIANT_HDR) begin
      valid_frame = (byte_cnt_nxt >= MIN_LEN_HDR) && hdr_ok_nxt;
      overhead    = OVH_HDR;
    end else begin
      valid_frame = (byte_cnt_nxt >= MIN_LEN_CRC) &&
                    (crc_nxt == {recent_nxt[1], recent_nxt[2]});
      overhead    = OVH_CRC;
    end
    diff          = (byte_cnt_nxt > overhead) ? byte_cnt_nxt - overhead : 8'd0;
    frame_len_nxt = byte_cnt_nxt;
    data_len_nxt  = '0;
    if (byte_cnt_nxt == '0) begin
      outcome_nxt = OUT_NO_RESP;
    end else if (!valid_frame) begin
      outcome_nxt = OUT_INVALID;
    end else begin
      outcome_nxt  = OUT_GOOD;
      data_len_nxt = diff[7] ? 7'h7F : diff[6:0];
    end
    out_valid_nxt = back_ready ? finish : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r     <= 1'b0;
      byte_cnt_r    <= '0;
      quiet_cnt_r   <= '0;
      elapsed_cnt_r <= '0;
      crc_r         <= CRC_INIT;
      recent_r      <= '{default: 8'h00};
      hdr_ok_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      waiting_r     <= waiting_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
      quiet_cnt_r   <= quiet_cnt_nxt;
      elapsed_cnt_r <= elapsed_cnt_nxt;
      crc_r         <= crc_nxt;
      recent_r      <= recent_nxt;
      hdr_ok_r      <= hdr_ok_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (finish) begin
      outcome_r   <= outcome_nxt;
      cause_r     <= cause_nxt;
      frame_len_r <= frame_len_nxt;
      data_len_r  <= data_len_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_outcome   = outcome_r;
  assign out_end_cause = cause_r;
  assign out_frame_len = frame_len_r;
  assign out_data_len  = data_len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= 8'(BUFFER_BYTES))
    else $error("byte count past buffer size");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_op.kind == OP_START) |=> waiting_r)
    else $error("start did not arm receiver");

  a_finish_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (!waiting_r && out_valid_r))
    else $error("frame end did not disarm or post result");

  a_len_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_len != '0) |-> (out_outcome == OUT_GOOD))
    else $error("data length on failed frame");

endmodule

// ----- design/response_frame_receiver_crc16.sv -----
// top level of the serial response frame receiver with crc16 check
// a word passes the front register, the queue and the result register in turn;
// the crc update for each byte is combinational
// throughput: one input word per cycle while in_ready is high
// reset: synchronous active-low rst_n disarms the receiver, empties the queue and
// loads register defaults (variant 0, quiet 40, timeout 600)
module response_frame_receiver_crc16 import rfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_outcome,
  output logic [1:0]       out_end_cause,
  output logic [7:0]       out_frame_len,
  output logic [6:0]       out_data_len,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic    push;
  op_t     push_op;
  logic    q_ready;
  logic    q_valid;
  logic    pop;
  op_t     pop_op;
  cfg_wr_t cfg;

  assign cfg = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  rfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_rx_byte(in_rx_byte),
    .push      (push),
    .push_op   (push_op),
    .q_ready   (q_ready)
  );

  rfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .q_ready(q_ready),
    .pop    (pop),
    .q_valid(q_valid),
    .pop_op (pop_op)
  );

  rfr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .pop_op       (pop_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_outcome  (out_outcome),
    .out_end_cause(out_end_cause),
    .out_frame_len(out_frame_len),
    .out_data_len (out_data_len)
  );

endmodule

// ----- sim/response_frame_receiver_crc16_tb.sv -----
// testbench for the serial response frame receiver: predicted frame reports vs block output
`timescale 1ns / 100ps

module response_frame_receiver_crc16_tb;
  import rfr_pkg::*;

  localparam logic [1:0] FUNC_RSVD = 2'd3;

  typedef struct packed {
    logic [1:0] outcome;
    logic [1:0] end_cause;
    logic [7:0] frame_len;
    logic [6:0] data_len;
  } frame_report_t;

  typedef logic [7:0] byte_q_t[$];

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_func = FUNC_TICK;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_outcome;
  logic [1:0]       out_end_cause;
  logic [7:0]       out_frame_len;
  logic [6:0]       out_data_len;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_VARIANT;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [1:0]       variant_reg;
  logic [CNT_W-1:0] quiet_reg;
  logic [CNT_W-1:0] timeout_reg;
  bit               rx_armed;
  int               rx_count;
  logic [CNT_W-1:0] quiet_cnt;
  logic [CNT_W-1:0] elapsed_cnt;
  logic [15:0]      crc_acc;
  logic [7:0]       last3 [0:2];
  bit               hdr_seen;

  frame_report_t expected_reports[$];
  int            errors = 0;
  int            used_words = 0;
  int            hold_cycles = 0;
  bit            sender_idle = 1'b1;
  bit            recv_idle = 1'b1;

  response_frame_receiver_crc16 DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_outcome  (out_outcome),
    .out_end_cause(out_end_cause),
    .out_frame_len(out_frame_len),
    .out_data_len (out_data_len),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_frame();
    rx_count = 0;
    quiet_cnt = '0;
    elapsed_cnt = '0;
    crc_acc = CRC_INIT;
    last3[0] = 8'h00;
    last3[1] = 8'h00;
    last3[2] = 8'h00;
    hdr_seen = 1'b0;
  endtask

  task automatic reset_model();
    variant_reg = 2'd0;
    quiet_reg = QUIET_RST;
    timeout_reg = TIMEOUT_RST;
    rx_armed = 1'b0;
    clear_frame();
  endtask

  task automatic track_word(input logic [1:0] f, input logic [7:0] b);
    frame_report_t rep;
    logic [1:0]    cause;
    bit            good;
    int            ovh;
    if (f == FUNC_START) begin
      clear_frame();
      rx_armed = 1'b1;
      return;
    end
    if (!rx_armed || f == FUNC_RSVD) return;
    if (f == FUNC_BYTE) begin
      if (rx_count < BUFFER_BYTES) begin
        if (rx_count >= 4) crc_acc = crc16_step(crc_acc, last3[2]);
        case (rx_count)
          0: hdr_seen = (b == HDR_B0);
          1: hdr_seen = hdr_seen && (b == HDR_B1);
          2: hdr_seen = hdr_seen && (b == HDR_B2);
          default: ;
        endcase
        last3[2] = last3[1];
        last3[1] = last3[0];
        last3[0] = b;
        rx_count++;
        quiet_cnt = '0;
      end
    end else begin
      if (quiet_cnt != CNT_MAX) quiet_cnt++;
      if (elapsed_cnt != CNT_MAX) elapsed_cnt++;
    end

    if (rx_count >= BUFFER_BYTES) begin
      cause = END_FULL;
    end else if (rx_count > 0 && quiet_cnt >= quiet_reg) begin
      cause = END_QUIET;
    end else if (elapsed_cnt >= timeout_reg) begin
      cause = END_TIMEOUT;
    end else begin
      return;
    end

    rx_armed = 1'b0;
    if (variant_reg == VARIANT_HDR) begin
      good = rx_count >= MIN_LEN_HDR && hdr_seen;
      ovh = OVH_HDR;
    end else begin
      good = rx_count >= MIN_LEN_CRC && crc_acc == {last3[1], last3[2]};
      ovh = OVH_CRC;
    end
    rep.end_cause = cause;
    rep.frame_len = 8'(rx_count);
    rep.data_len = 7'd0;
    if (rx_count == 0) begin
      rep.outcome = OUT_NO_RESP;
    end else if (!good) begin
      rep.outcome = OUT_INVALID;
    end else begin
      rep.outcome = OUT_GOOD;
      if (rx_count > ovh) rep.data_len = 7'(rx_count - ovh);
    end
    expected_reports.push_back(rep);
  endtask

  task automatic send_word(input logic [1:0] f, input logic [7:0] b);
    int gap;
    bit took;
    gap = sender_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    used_words++;
    track_word(f, b);
  endtask

  task automatic wait_drain();
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic close_frame();
    int guard;
    guard = 0;
    while (rx_armed && guard < 1100) begin
      send_word(FUNC_TICK, 8'($urandom_range(0, 255)));
      guard++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_VARIANT: variant_reg = val[1:0];
      CFG_QUIET:   quiet_reg = val;
      CFG_TIMEOUT: timeout_reg = val;
      default: ;
    endcase
  endtask

  // closes any open frame and lets the pipeline empty before the writes
  task automatic configure(input int v, input int q, input int t);
    close_frame();
    in_valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    write_reg(CFG_VARIANT, CNT_W'(v));
    write_reg(CFG_QUIET, CNT_W'(q));
    write_reg(CFG_TIMEOUT, CNT_W'(t));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_frame(input int n, input bit hdr_style, output byte_q_t fr);
    logic [15:0] c;
    fr.delete();
    for (int i = 0; i < n; i++) fr.push_back(8'($urandom_range(0, 255)));
    if (hdr_style) begin
      if (n > 0) fr[0] = HDR_B0;
      if (n > 1) fr[1] = HDR_B1;
      if (n > 2) fr[2] = HDR_B2;
    end else if (n >= 5) begin
      c = CRC_INIT;
      for (int i = 1; i <= n - 4; i++) c = crc16_step(c, fr[i]);
      fr[n-3] = c[7:0];
      fr[n-2] = c[15:8];
    end
  endtask

  task automatic play_frame(input byte_q_t fr);
    int gap;
    send_word(FUNC_START, 8'($urandom_range(0, 255)));
    foreach (fr[i]) begin
      gap = int'(quiet_reg) - 1;
      if (gap > 5) gap = 5;
      if (gap > 0 && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, gap)) send_word(FUNC_TICK, 8'($urandom_range(0, 255)));
      end
      send_word(FUNC_BYTE, fr[i]);
    end
    close_frame();
  endtask

  task automatic test_directed_basics();
    byte_q_t fr;
    configure(0, 2, 4);
    // idle words are dropped
    send_word(FUNC_TICK, 8'h00);
    send_word(FUNC_BYTE, 8'hFF);
    send_word(FUNC_RSVD, 8'hAA);
    // restart while armed, then time out with no bytes
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_START, 8'hFF);
    repeat (4) send_word(FUNC_TICK, 8'h55);
    // short frame ended by quiet line
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'hFF);
    send_word(FUNC_TICK, 8'h00);
    send_word(FUNC_TICK, 8'h00);
    // shortest good crc frame with an unused code inside
    build_frame(5, 1'b0, fr);
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_RSVD, 8'h00);
    foreach (fr[i]) send_word(FUNC_BYTE, fr[i]);
    close_frame();
  endtask

  task automatic test_header_variant();
    byte_q_t fr;
    configure(1, 3, 50);
    build_frame(12, 1'b1, fr);
    play_frame(fr);
    build_frame(3, 1'b1, fr);
    play_frame(fr);
    build_frame(8, 1'b1, fr);
    fr[2] = 8'd7;
    play_frame(fr);
    build_frame(2, 1'b1, fr);
    play_frame(fr);
    build_frame(10, 1'b0, fr);
    play_frame(fr);
    configure(2, 3, 50);
    build_frame(20, 1'b0, fr);
    play_frame(fr);
    build_frame(9, 1'b1, fr);
    play_frame(fr);
  endtask

  task automatic test_edge_limits();
    byte_q_t fr;
    // quiet wins over timeout on the same tick
    configure(0, 1, 1);
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_BYTE, 8'h12);
    send_word(FUNC_TICK, 8'h00);
    configure(0, 1023, 1);
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_BYTE, 8'h34);
    send_word(FUNC_TICK, 8'h00);
    send_word(FUNC_START, 8'h00);
    send_word(FUNC_TICK, 8'h00);
    configure(0, 1023, 1023);
    build_frame(3, 1'b0, fr);
    play_frame(fr);
    // buffer full, then words after the frame are dropped
    configure(0, 3, 1023);
    build_frame(BUFFER_BYTES, 1'b0, fr);
    play_frame(fr);
    send_word(FUNC_BYTE, 8'h01);
    send_word(FUNC_TICK, 8'h02);
    build_frame(BUFFER_BYTES + 2, 1'b0, fr);
    play_frame(fr);
    configure(1, 3, 1023);
    build_frame(BUFFER_BYTES, 1'b1, fr);
    play_frame(fr);
  endtask

  task automatic test_backpressure();
    configure(0, 1, 20);
    sender_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles = 400;
    repeat (40) begin
      send_word(FUNC_START, 8'h00);
      send_word(FUNC_BYTE, 8'($urandom_range(0, 255)));
      send_word(FUNC_TICK, 8'h00);
    end
    in_valid <= 1'b0;
    wait_drain();
    sender_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_drain_pauses();
    byte_q_t fr;
    configure(0, 2, 40);
    repeat (6) begin
      build_frame($urandom_range(5, 14), 1'b0, fr);
      play_frame(fr);
      in_valid <= 1'b0;
      wait_drain();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic test_random_traffic();
    byte_q_t fr;
    int      frames, r, n, idx;
    bit      hdr;
    frames = 0;
    while (used_words < 1950) begin
      if (frames % 12 == 0) begin
        configure($urandom_range(0, 2),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 6),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : $urandom_range(10, 80));
        sender_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      frames++;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        r = $urandom_range(0, 99);
        if (r < 70) n = $urandom_range(5, 16);
        else if (r < 85) n = $urandom_range(1, 4);
        else if (r < 97) n = $urandom_range(17, 40);
        else n = $urandom_range(120, 140);
        hdr = (variant_reg == VARIANT_HDR) ^ ($urandom_range(0, 4) == 0);
        build_frame(n, hdr, fr);
        if ($urandom_range(0, 9) == 0) begin
          idx = $urandom_range(0, n - 1);
          fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        play_frame(fr);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        // abandoned frame: the next start rearms
        send_word(FUNC_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 5)) send_word(FUNC_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // result side
  initial begin
    int stall;
    bit took;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  always @(negedge clk) begin : check_results
    frame_report_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_outcome, out_end_cause, out_frame_len, out_data_len};
      if (expected_reports.size() == 0) begin
        report_error($sformatf("unexpected word outcome %0d cause %0d len %0d data %0d",
                               got.outcome, got.end_cause, got.frame_len, got.data_len));
      end else begin
        want = expected_reports.pop_front();
        if (got.outcome != want.outcome)
          report_error($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
        if (got.end_cause != want.end_cause)
          report_error($sformatf("end_cause got %0d want %0d", got.end_cause, want.end_cause));
        if (got.frame_len != want.frame_len)
          report_error($sformatf("frame_len got %0d want %0d", got.frame_len, want.frame_len));
        if (got.data_len != want.data_len)
          report_error($sformatf("data_len got %0d want %0d", got.data_len, want.data_len));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_header_variant();
    test_edge_limits();
    test_backpressure();
    test_drain_pauses();
    test_random_traffic();
    in_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- response_frame_receiver_crc16.f -----
design/rfr_pkg.sv
design/rfr_front.sv
design/rfr_queue.sv
design/rfr_back.sv
design/response_frame_receiver_crc16.sv
sim/response_frame_receiver_crc16_tb.sv
